// ===== src/waypoint_segment_sequencer_top_macros.svh =====
// Assertion macros shared by the waypoint segment sequencer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef WAYPOINT_SEGMENT_SEQUENCER_TOP_MACROS_SVH
`define WAYPOINT_SEGMENT_SEQUENCER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is held
`define WSS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
    else $error("wss: same-cycle check failed");
// Next-cycle implication, disabled while reset is held
`define WSS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
    else $error("wss: next-cycle check failed");
`else
`define WSS_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define WSS_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// ===== src/wss_pkg.sv =====
// Shared types and constants of the waypoint segment sequencer.
// No dependencies; used by wss_ctrl, wss_datapath and the top level.
`default_nettype none

package wss_pkg;

  // Fixed field widths
  localparam int KIND_BITS    = 2;
  localparam int RADIUS_BITS  = 24;
  localparam int PENDING_BITS = 5;

  localparam logic [RADIUS_BITS-1:0] RADIUS_RESET = 24'd1000;

  // Item kinds carried in tuser
  localparam logic [KIND_BITS-1:0] KIND_WAYPOINT = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_POSITION = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_TICK     = 2'd2;

  // Shared multiplier operand select
  localparam logic [1:0] MUL_SEL_DX  = 2'd0;
  localparam logic [1:0] MUL_SEL_DY  = 2'd1;
  localparam logic [1:0] MUL_SEL_RAD = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic       ld_start;   // first waypoint becomes segment start
    logic       ld_goal;    // second waypoint becomes segment end
    logic       push;       // queue a waypoint
    logic       set_drop;   // queue full, set sticky flag
    logic       ld_pos;     // capture position estimate
    logic       diff;       // register |dx|, |dy|
    logic       mul_en;     // run the shared multiplier
    logic [1:0] mul_sel;
    logic       advance;    // advance segment if within radius
    logic       emit;       // load the output register
  } wss_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic near;
    logic out_free;
  } wss_sts_t;

endpackage

`default_nettype wire

// ===== src/wss_datapath.sv =====
// Datapath: segment registers, waypoint queue memory, squared-distance unit, output register.
// Depends on wss_pkg and waypoint_segment_sequencer_top_macros.svh.
`default_nettype none
`include "waypoint_segment_sequencer_top_macros.svh"

module wss_datapath #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COORD_BITS  = 24,
  parameter int OUT_TW      = 104
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire  wss_pkg::wss_cmd_t            cmd,
  output wss_pkg::wss_sts_t                  sts,
  input  wire  [COORD_BITS-1:0]              in_x,
  input  wire  [COORD_BITS-1:0]              in_y,
  input  wire                                cfg_we,
  input  wire  [wss_pkg::RADIUS_BITS-1:0]    cfg_radius,
  input  wire                                out_tready,
  output logic                               out_tvalid,
  output logic [OUT_TW-1:0]                  out_tdata
);

  localparam int CB  = COORD_BITS;
  localparam int RB  = wss_pkg::RADIUS_BITS;
  localparam int PB  = wss_pkg::PENDING_BITS;
  localparam int AW  = $clog2(QUEUE_DEPTH);
  localparam int FW  = $clog2(QUEUE_DEPTH + 1);
  localparam int MW  = (CB + 1 > RB) ? CB + 1 : RB;
  localparam int PW  = 2 * MW;

  // Configuration
  logic [RB-1:0] radius_r;

  // Segment end points
  logic [CB-1:0] start_x_r, start_y_r, goal_x_r, goal_y_r;

  // Queue bookkeeping
  logic [AW-1:0] head_r, tail_r;
  logic [FW-1:0] fill_r;
  logic          drop_r;

  // Queue memory, entry = {y, x}
  logic [2*CB-1:0] mem [QUEUE_DEPTH];
  logic [2*CB-1:0] rd_data_r;

  // Distance unit
  logic [CB-1:0]  pos_x_r, pos_y_r;
  logic [CB:0]    dx_r, dy_r;
  logic [PW-1:0]  prod_x_r, prod_y_r, prod_r_r;
  logic signed [CB:0] diff_x, diff_y;
  logic [CB:0]    mag_x, mag_y;
  logic [MW-1:0]  mul_op;
  logic [PW-1:0]  mul_res;
  logic [PW:0]    dist_sum;

  // Output register
  logic              out_valid_r;
  logic [OUT_TW-1:0] out_data_r;

  logic [AW-1:0] head_inc, tail_inc;
  logic          advance_go;

  // Pointer wrap
  assign head_inc = (head_r == AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign tail_inc = (tail_r == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + AW'(1);

  // Status
  assign sts.empty    = (fill_r == '0);
  assign sts.full     = (fill_r == FW'(QUEUE_DEPTH));
  assign sts.out_free = !out_valid_r || out_tready;
  assign dist_sum     = {1'b0, prod_x_r} + {1'b0, prod_y_r};
  assign sts.near     = (dist_sum < {1'b0, prod_r_r});

  assign advance_go = cmd.advance && sts.near;

  // Absolute differences to the goal, one bit wider than a coordinate
  always_comb begin
    diff_x = signed'({goal_x_r[CB-1], goal_x_r}) - signed'({pos_x_r[CB-1], pos_x_r});
    diff_y = signed'({goal_y_r[CB-1], goal_y_r}) - signed'({pos_y_r[CB-1], pos_y_r});
    mag_x  = diff_x[CB] ? unsigned'(-diff_x) : unsigned'(diff_x);
    mag_y  = diff_y[CB] ? unsigned'(-diff_y) : unsigned'(diff_y);
  end

  // Shared squarer operand
  always_comb begin
    case (cmd.mul_sel)
      wss_pkg::MUL_SEL_DX:  mul_op = MW'(dx_r);
      wss_pkg::MUL_SEL_DY:  mul_op = MW'(dy_r);
      wss_pkg::MUL_SEL_RAD: mul_op = MW'(radius_r);
      default:              mul_op = '0;
    endcase
    mul_res = PW'(mul_op) * PW'(mul_op);
  end

  // Arrival radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= wss_pkg::RADIUS_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_radius;
    end
  end

  // Queue memory: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail_r] <= {in_y, in_x};
    end
    rd_data_r <= mem[head_r];
  end

  // Queue pointers, fill level and sticky drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
      drop_r <= 1'b0;
    end else begin
      if (cmd.push) begin
        tail_r <= tail_inc;
        fill_r <= fill_r + FW'(1);
      end else if (advance_go) begin
        head_r <= head_inc;
        fill_r <= fill_r - FW'(1);
      end
      if (cmd.set_drop) begin
        drop_r <= 1'b1;
      end
    end
  end

  // Segment start and end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_x_r <= '0;
      start_y_r <= '0;
      goal_x_r  <= '0;
      goal_y_r  <= '0;
    end else if (cmd.ld_start) begin
      start_x_r <= in_x;
      start_y_r <= in_y;
    end else if (cmd.ld_goal) begin
      goal_x_r <= in_x;
      goal_y_r <= in_y;
    end else if (advance_go) begin
      start_x_r <= goal_x_r;
      start_y_r <= goal_y_r;
      goal_x_r  <= rd_data_r[CB-1:0];
      goal_y_r  <= rd_data_r[2*CB-1:CB];
    end
  end

  // Distance pipeline registers
  always_ff @(posedge clk) begin
    if (cmd.ld_pos) begin
      pos_x_r <= in_x;
      pos_y_r <= in_y;
    end
    if (cmd.diff) begin
      dx_r <= mag_x;
      dy_r <= mag_y;
    end
    if (cmd.mul_en) begin
      case (cmd.mul_sel)
        wss_pkg::MUL_SEL_DX:  prod_x_r <= mul_res;
        wss_pkg::MUL_SEL_DY:  prod_y_r <= mul_res;
        wss_pkg::MUL_SEL_RAD: prod_r_r <= mul_res;
        default:              prod_r_r <= prod_r_r;
      endcase
    end
  end

  // Output register: {overflowed, pending_count, end_y, end_x, start_y, start_x}
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= OUT_TW'({drop_r, PB'(fill_r), goal_y_r, goal_x_r, start_y_r, start_x_r});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  `WSS_ASSERT_IMPL(a_fill_bound, clk, rst_n, 1'b1, fill_r <= FW'(QUEUE_DEPTH))
  `WSS_ASSERT_IMPL(a_emit_free, clk, rst_n, cmd.emit, !out_valid_r || out_tready)
  `WSS_ASSERT_NEXT(a_drop_sticky, clk, rst_n, drop_r, drop_r)
  `WSS_ASSERT_IMPL(a_no_pop_empty, clk, rst_n, advance_go, fill_r != '0)

endmodule

`default_nettype wire

// ===== src/wss_ctrl.sv =====
// Controller FSM: decodes item kinds, tracks waypoints seen, sequences the distance check.
// Depends on wss_pkg and waypoint_segment_sequencer_top_macros.svh.
`default_nettype none
`include "waypoint_segment_sequencer_top_macros.svh"

module wss_ctrl (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  input  wire  [wss_pkg::KIND_BITS-1:0]      in_kind,
  output wss_pkg::wss_cmd_t                  cmd,
  input  wire  wss_pkg::wss_sts_t            sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIFF = 3'd1;
  localparam logic [2:0] ST_MX   = 3'd2;
  localparam logic [2:0] ST_MY   = 3'd3;
  localparam logic [2:0] ST_MR   = 3'd4;
  localparam logic [2:0] ST_CMP  = 3'd5;
  localparam logic [2:0] ST_EMIT = 3'd6;

  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_TWO  = 2'd2;

  logic [2:0] state_r, state_nxt;
  logic [1:0] seen_r, seen_nxt;
  logic       accept;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    seen_nxt  = seen_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_kind)
            wss_pkg::KIND_WAYPOINT: begin
              if (seen_r == SEEN_NONE) begin
                cmd.ld_start = 1'b1;
                seen_nxt     = SEEN_ONE;
              end else if (seen_r == SEEN_ONE) begin
                cmd.ld_goal = 1'b1;
                seen_nxt    = SEEN_TWO;
              end else if (sts.full) begin
                cmd.set_drop = 1'b1;
              end else begin
                cmd.push = 1'b1;
              end
            end
            wss_pkg::KIND_POSITION: begin
              if (!sts.empty) begin
                cmd.ld_pos = 1'b1;
                state_nxt  = ST_DIFF;
              end
            end
            wss_pkg::KIND_TICK: begin
              if (seen_r == SEEN_TWO) begin
                if (sts.out_free) begin
                  cmd.emit = 1'b1;
                end else begin
                  state_nxt = ST_EMIT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIFF: begin
        cmd.diff  = 1'b1;
        state_nxt = ST_MX;
      end
      ST_MX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wss_pkg::MUL_SEL_DX;
        state_nxt   = ST_MY;
      end
      ST_MY: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wss_pkg::MUL_SEL_DY;
        state_nxt   = ST_MR;
      end
      ST_MR: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = wss_pkg::MUL_SEL_RAD;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        cmd.advance = 1'b1;
        state_nxt   = ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      seen_r  <= SEEN_NONE;
    end else begin
      state_r <= state_nxt;
      seen_r  <= seen_nxt;
    end
  end

  // Checks
  `WSS_ASSERT_IMPL(a_accept_idle, clk, rst_n, in_tvalid && in_tready, state_r == ST_IDLE)
  `WSS_ASSERT_IMPL(a_seen_sat, clk, rst_n, 1'b1, seen_r <= SEEN_TWO)
  `WSS_ASSERT_NEXT(a_pos_starts, clk, rst_n, cmd.ld_pos, state_r == ST_DIFF)

endmodule

`default_nettype wire

// ===== src/waypoint_segment_sequencer_top.sv =====
// Top level of the waypoint segment sequencer: stream ports, controller and datapath.
// Depends on wss_pkg, wss_ctrl and wss_datapath.
//
// Keeps a guidance segment (start, end) and a queue of up to QUEUE_DEPTH pending
// waypoints. Waypoint items and most publish ticks leave the block idle; kind 3 is ignored.
// A position item with a non-empty queue holds off further items until the check
// is done: |dx|,|dy| are registered, then one shared squarer computes dx^2, dy^2
// and r^2 in turn, and a last state compares the sum and advances the segment.
// A tick that finds the output register still occupied waits there, holding off
// further items, until the previous result is taken. The arrival radius may be
// written at any time the block is idle; cfg_tready is always high.
`default_nettype none

module waypoint_segment_sequencer_top #(
  parameter int QUEUE_DEPTH = 16,
  parameter int COORD_BITS  = 24
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  // Input stream
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  input  wire  [((2*COORD_BITS+7)/8)*8-1:0]      in_tdata,  // x_coord, y_coord
  input  wire  [wss_pkg::KIND_BITS-1:0]          in_tuser,  // kind
  // Result stream
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // seg_start_x, seg_start_y, seg_end_x, seg_end_y, pending_count, overflowed
  output logic [((4*COORD_BITS+wss_pkg::PENDING_BITS+1+7)/8)*8-1:0] out_tdata,
  // Configuration write
  input  wire                                    cfg_tvalid,
  output logic                                   cfg_tready,
  input  wire  [wss_pkg::RADIUS_BITS-1:0]        cfg_tdata  // arrival_radius_mm
);

  localparam int OUT_TW = ((4*COORD_BITS + wss_pkg::PENDING_BITS + 1 + 7) / 8) * 8;

  wss_pkg::wss_cmd_t cmd;
  wss_pkg::wss_sts_t sts;

  assign cfg_tready = 1'b1;

  wss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_kind   (in_tuser),
    .cmd       (cmd),
    .sts       (sts)
  );

  wss_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .COORD_BITS  (COORD_BITS),
    .OUT_TW      (OUT_TW)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_x       (in_tdata[COORD_BITS-1:0]),
    .in_y       (in_tdata[2*COORD_BITS-1:COORD_BITS]),
    .cfg_we     (cfg_tvalid && cfg_tready),
    .cfg_radius (cfg_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/waypoint_segment_sequencer_top_tb.sv =====
// Self-checking testbench for waypoint_segment_sequencer_top: stream driver, result monitor,
// and a predictor of the segment, the waypoint queue and the sticky drop flag.
// Depends on wss_pkg and the RTL of waypoint_segment_sequencer_top.
`default_nettype none

module waypoint_segment_sequencer_top_tb;

  localparam int COORD_W        = 24;
  localparam int QDEPTH         = 16;
  localparam int IN_W           = ((2*COORD_W+7)/8)*8;
  localparam int OUT_W          = ((4*COORD_W+wss_pkg::PENDING_BITS+1+7)/8)*8;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 30;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_OFF_LEN   = 150;
  localparam int HOLD_OFF_AT    = 60;
  localparam int QUIET_TAIL     = 150;
  localparam logic [wss_pkg::KIND_BITS-1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7fffff;
  localparam logic signed [COORD_W-1:0] COORD_MIN = -24'sh800000;
  localparam logic [wss_pkg::RADIUS_BITS-1:0] RADIUS_MAX = 24'hffffff;

  typedef logic signed [COORD_W-1:0] coord_t;

  // One entry of the stimulus feed: an input transaction or a radius write
  typedef struct packed {
    logic                            is_cfg;
    logic [wss_pkg::KIND_BITS-1:0]   kind;
    coord_t                          x;
    coord_t                          y;
    logic [wss_pkg::RADIUS_BITS-1:0] radius;
  } feed_t;

  typedef struct packed {
    logic [COORD_W-1:0]               start_x;
    logic [COORD_W-1:0]               start_y;
    logic [COORD_W-1:0]               end_x;
    logic [COORD_W-1:0]               end_y;
    logic [wss_pkg::PENDING_BITS-1:0] pending;
    logic                             overflowed;
  } segment_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [IN_W-1:0]    in_tdata = '0;    // x_coord, y_coord
  logic [wss_pkg::KIND_BITS-1:0] in_tuser = '0;  // kind
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [OUT_W-1:0]   out_tdata;        // start x/y, end x/y, pending_count, overflowed
  logic               cfg_tvalid = 1'b0;
  logic               cfg_tready;
  logic [wss_pkg::RADIUS_BITS-1:0] cfg_tdata = '0;

  waypoint_segment_sequencer_top #(
    .QUEUE_DEPTH(QDEPTH),
    .COORD_BITS (COORD_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_tvalid(cfg_tvalid),
    .cfg_tready(cfg_tready),
    .cfg_tdata (cfg_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  feed_t    feed[$];
  segment_t expected_segments[$];
  int       fail_count = 0;
  logic     quiet_tail = 1'b0;

  // Exact arrival test: dx^2 + dy^2 < r^2, no overflow at these widths
  function automatic bit near_goal(coord_t gx, coord_t gy, coord_t px, coord_t py,
                                   logic [wss_pkg::RADIUS_BITS-1:0] r);
    longint dx, dy;
    longint unsigned dist_sq, r_sq;
    dx = longint'(gx) - longint'(px);
    dy = longint'(gy) - longint'(py);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    dist_sq = dx * dx + dy * dy;
    r_sq = r;
    r_sq = r_sq * r_sq;
    return dist_sq < r_sq;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    fail_count++;
    $display("%0t mismatch: %s got 0x%0h expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor state: segment, waypoint ring and drop flag as the block holds them
  logic [wss_pkg::RADIUS_BITS-1:0] radius_reg = wss_pkg::RADIUS_RESET;
  coord_t                 seg_sx = '0, seg_sy = '0, seg_gx = '0, seg_gy = '0;
  logic [1:0]             wp_seen = '0;
  logic [2*COORD_W-1:0]   ring[QDEPTH];
  logic [3:0]             ring_head = '0, ring_tail = '0;
  logic [wss_pkg::PENDING_BITS-1:0] ring_fill = '0;
  logic                   dropped = 1'b0;

  task automatic sequence_step(input logic [wss_pkg::KIND_BITS-1:0] kind, input coord_t px,
                               input coord_t py);
    segment_t seg;
    if (kind == wss_pkg::KIND_WAYPOINT) begin
      if (wp_seen == 2'd0) begin
        seg_sx = px; seg_sy = py; wp_seen = 2'd1;
      end else if (wp_seen == 2'd1) begin
        seg_gx = px; seg_gy = py; wp_seen = 2'd2;
      end else if (ring_fill >= QDEPTH) begin
        dropped = 1'b1;
      end else begin
        ring[ring_tail] = {py, px};
        ring_tail = ring_tail + 4'd1;
        ring_fill = ring_fill + 1'b1;
      end
    end else if (kind == wss_pkg::KIND_POSITION) begin
      if (ring_fill != 0 && near_goal(seg_gx, seg_gy, px, py, radius_reg)) begin
        seg_sx = seg_gx; seg_sy = seg_gy;
        {seg_gy, seg_gx} = ring[ring_head];
        ring_head = ring_head + 4'd1;
        ring_fill = ring_fill - 1'b1;
      end
    end else if (kind == wss_pkg::KIND_TICK && wp_seen == 2'd2) begin
      seg.start_x = seg_sx; seg.start_y = seg_sy;
      seg.end_x = seg_gx;   seg.end_y = seg_gy;
      seg.pending = ring_fill;
      seg.overflowed = dropped;
      expected_segments.insert(expected_segments.size(), seg);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus generation, with a coarse shadow of the goal to aim positions at it
  logic [wss_pkg::RADIUS_BITS-1:0] gen_radius = wss_pkg::RADIUS_RESET;
  int                     gen_seen = 0;
  coord_t                 gen_gx = '0, gen_gy = '0, last_wx = '0, last_wy = '0;
  logic [2*COORD_W-1:0]   gen_queue[$];

  function automatic coord_t clamp_coord(longint v);
    if (v > longint'(COORD_MAX)) return COORD_MAX;
    if (v < longint'(COORD_MIN)) return COORD_MIN;
    return coord_t'(v);
  endfunction

  function automatic coord_t rand_coord();
    logic [31:0] r;
    r = $urandom;
    return r[COORD_W-1:0];
  endfunction

  function automatic coord_t jitter(coord_t c, longint span);
    longint off;
    off = longint'($urandom_range(0, 32'(2 * span))) - span;
    return clamp_coord(longint'(c) + off);
  endfunction

  task automatic push_item(input logic [wss_pkg::KIND_BITS-1:0] kind, input coord_t px,
                           input coord_t py);
    feed_t f;
    f.is_cfg = 1'b0; f.kind = kind; f.x = px; f.y = py; f.radius = '0;
    feed.insert(feed.size(), f);
    if (kind == wss_pkg::KIND_WAYPOINT) begin
      if (gen_seen < 2) begin
        gen_seen++;
        gen_gx = px; gen_gy = py;
      end else if (gen_queue.size() < QDEPTH) begin
        gen_queue.insert(gen_queue.size(), {py, px});
      end
      last_wx = px; last_wy = py;
    end else if (kind == wss_pkg::KIND_POSITION && gen_queue.size() > 0 &&
                 near_goal(gen_gx, gen_gy, px, py, gen_radius)) begin
      {gen_gy, gen_gx} = gen_queue[0];
      gen_queue.delete(0);
    end
  endtask

  task automatic push_radius(input logic [wss_pkg::RADIUS_BITS-1:0] r);
    feed_t f;
    f = '0;
    f.is_cfg = 1'b1; f.radius = r;
    feed.insert(feed.size(), f);
    gen_radius = r;
  endtask

  // Position that is sure to arrive (for r > 0), or one that may miss
  task automatic push_position(input bit aim);
    longint span;
    span = aim ? longint'(gen_radius / 2) : longint'(gen_radius) * 2 + 8;
    if (span > 64'd4194304) span = 64'd4194304;
    if (!aim && $urandom_range(0, 3) == 0)
      push_item(wss_pkg::KIND_POSITION, rand_coord(), rand_coord());
    else
      push_item(wss_pkg::KIND_POSITION, jitter(gen_gx, span), jitter(gen_gy, span));
  endtask

  task automatic gen_phase(input int n, input bit allow_drop, input int wp_pct);
    int   roll;
    bit   full;
    longint span;
    logic [wss_pkg::KIND_BITS-1:0] k;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      full = gen_queue.size() >= QDEPTH;
      span = longint'(gen_radius) * 2 + 16;
      if (span > 64'd4194304) span = 64'd4194304;
      if (roll < 5) begin
        push_item(KIND_UNUSED, rand_coord(), rand_coord());
      end else if (roll < 12) begin
        // raw noise across the whole coordinate range
        k = ($urandom_range(0, 1) != 0) ? wss_pkg::KIND_POSITION : wss_pkg::KIND_WAYPOINT;
        if (k == wss_pkg::KIND_WAYPOINT && full && !allow_drop) k = wss_pkg::KIND_POSITION;
        push_item(k, rand_coord(), rand_coord());
      end else if (roll < 32 && gen_seen >= 2) begin
        push_item(wss_pkg::KIND_TICK, rand_coord(), rand_coord());
      end else if (gen_seen < 2 || roll < 32 + wp_pct) begin
        if (full && !allow_drop)
          push_position(1'b1);
        else if ($urandom_range(0, 4) == 0)
          push_item(wss_pkg::KIND_WAYPOINT, rand_coord(), rand_coord());
        else
          push_item(wss_pkg::KIND_WAYPOINT, jitter(last_wx, span), jitter(last_wy, span));
      end else begin
        push_position($urandom_range(0, 99) < 65);
      end
    end
  endtask

  // Short directed sequence at the reset radius of 1000
  task automatic gen_directed();
    push_item(wss_pkg::KIND_TICK, '0, '0);                     // tick before any waypoint
    push_item(wss_pkg::KIND_POSITION, '0, '0);                 // position with no goal yet
    push_item(KIND_UNUSED, COORD_MIN, COORD_MAX);              // unused kind
    push_item(KIND_UNUSED, '1, '1);
    push_item(wss_pkg::KIND_WAYPOINT, COORD_MIN, COORD_MAX);   // segment start
    push_item(wss_pkg::KIND_TICK, '0, '0);                     // only one waypoint known
    push_item(wss_pkg::KIND_WAYPOINT, COORD_MAX, COORD_MIN);   // segment end
    push_item(wss_pkg::KIND_TICK, COORD_MAX, COORD_MIN);
    push_item(wss_pkg::KIND_POSITION, COORD_MAX, COORD_MIN);   // arrival with an empty queue
    push_item(wss_pkg::KIND_TICK, '0, '0);
    push_item(wss_pkg::KIND_WAYPOINT, '0, '0);
    push_item(wss_pkg::KIND_WAYPOINT, -24'sd1, -24'sd1);
    push_item(wss_pkg::KIND_WAYPOINT, 24'sd100, 24'sd200);
    push_item(wss_pkg::KIND_POSITION, COORD_MIN, COORD_MAX);   // farthest possible point
    push_item(wss_pkg::KIND_TICK, '0, '0);
    push_item(wss_pkg::KIND_POSITION, COORD_MAX - 24'sd999, COORD_MIN);  // just inside
    push_item(wss_pkg::KIND_TICK, '0, '0);
    push_item(wss_pkg::KIND_POSITION, '0, 24'sd1000);          // exactly on the radius
    push_item(wss_pkg::KIND_POSITION, 24'sd600, 24'sd799);     // inside by a hair
    push_item(wss_pkg::KIND_TICK, '0, '0);
    push_item(KIND_UNUSED, '0, '0);
    push_item(wss_pkg::KIND_TICK, '1, '1);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: input stream and radius writes
  int in_gap = 0;
  int settle_cnt = 0;
  int items_taken = 0;

  always @(posedge clk) begin : drive_seq
    feed_t nxt;
    logic  nxt_in_valid, nxt_cfg_valid;
    if (!rst_n) begin
      in_tvalid  <= 1'b0;
      cfg_tvalid <= 1'b0;
    end else begin
      nxt_in_valid  = in_tvalid;
      nxt_cfg_valid = cfg_tvalid;
      if (in_tvalid && in_tready) begin
        sequence_step(in_tuser, in_tdata[COORD_W-1:0], in_tdata[2*COORD_W-1:COORD_W]);
        nxt_in_valid = 1'b0;
        items_taken++;
        if (!quiet_tail && (items_taken / 200) % 3 != 2 && $urandom_range(0, 99) < 20)
          in_gap = $urandom_range(1, 6);
      end
      if (cfg_tvalid && cfg_tready) begin
        radius_reg = cfg_tdata;
        nxt_cfg_valid = 1'b0;
      end
      // radius writes wait until the block has drained
      if (expected_segments.size() == 0 && !in_tvalid && !cfg_tvalid) settle_cnt++;
      else settle_cnt = 0;
      if (!nxt_in_valid && !nxt_cfg_valid && feed.size() > 0) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (feed[0].is_cfg) begin
          if (settle_cnt >= SETTLE_CYCLES) begin
            nxt = feed[0];
            feed.delete(0);
            cfg_tdata <= nxt.radius;
            nxt_cfg_valid = 1'b1;
          end
        end else begin
          nxt = feed[0];
          feed.delete(0);
          in_tuser <= nxt.kind;
          in_tdata <= {nxt.y, nxt.x};
          nxt_in_valid = 1'b1;
        end
      end
      in_tvalid  <= nxt_in_valid;
      cfg_tvalid <= nxt_cfg_valid;
      quiet_tail <= (feed.size() < QUIET_TAIL);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: result checks and receiver back-pressure
  int  stall_left = 0;
  int  results_taken = 0;
  bit  held_off = 1'b0;

  always @(posedge clk) begin : monitor_seq
    segment_t want;
    logic     nxt_ready;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_taken++;
        if (expected_segments.size() == 0) begin
          report_mismatch("unexpected segment transaction", out_tdata[31:0], '0);
        end else begin
          want = expected_segments[0];
          expected_segments.delete(0);
          check_field("seg_start_x", out_tdata[COORD_W-1:0], want.start_x);
          check_field("seg_start_y", out_tdata[2*COORD_W-1:COORD_W], want.start_y);
          check_field("seg_end_x", out_tdata[3*COORD_W-1:2*COORD_W], want.end_x);
          check_field("seg_end_y", out_tdata[4*COORD_W-1:3*COORD_W], want.end_y);
          check_field("pending_count",
                      out_tdata[4*COORD_W+wss_pkg::PENDING_BITS-1:4*COORD_W], want.pending);
          check_field("overflowed", out_tdata[4*COORD_W+wss_pkg::PENDING_BITS],
                      want.overflowed);
        end
      end
      // one long hold-off so the output register fills and the input stalls
      if (!held_off && results_taken >= HOLD_OFF_AT) begin
        held_off = 1'b1;
        stall_left = HOLD_OFF_LEN;
      end
      if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (!quiet_tail && (results_taken / 50) % 3 != 2 &&
                   $urandom_range(0, 99) < 15) begin
        stall_left = $urandom_range(0, 5);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_tready <= nxt_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: too long without any transaction ends the run
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
          (cfg_tvalid && cfg_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("waypoint_segment_sequencer_top_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Build the feed, release reset, wait for the drain and report
  initial begin
    gen_directed();
    push_radius('0);
    gen_phase(150, 1'b0, 25);
    push_radius(RADIUS_MAX);
    gen_phase(200, 1'b0, 30);
    push_radius(24'd1);
    gen_phase(150, 1'b0, 30);
    push_radius(24'($urandom_range(2, 5000)));
    gen_phase(300, 1'b0, 30);
    push_radius(24'($urandom));
    gen_phase(200, 1'b0, 30);
    push_radius(wss_pkg::RADIUS_RESET);
    // flood the queue so waypoints are dropped
    for (int i = 0; i < 20; i++)
      push_item(wss_pkg::KIND_WAYPOINT, rand_coord(), rand_coord());
    gen_phase(250, 1'b1, 40);
    push_radius(24'($urandom_range(2, 20000)));
    gen_phase(300, 1'b1, 30);
    push_radius(RADIUS_MAX);
    gen_phase(250, 1'b1, 30);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (feed.size() != 0 || in_tvalid || cfg_tvalid || expected_segments.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0)
      $display("waypoint_segment_sequencer_top_tb: PASS");
    else
      $display("waypoint_segment_sequencer_top_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+src
src/wss_pkg.sv
src/wss_datapath.sv
src/wss_ctrl.sv
src/waypoint_segment_sequencer_top.sv
tb/waypoint_segment_sequencer_top_tb.sv
